FILE: hdl/aotm_pkg.sv
// Shared types, constants and the CORDIC angle table for the arctangent overdrive.
package aotm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 13;
  localparam int TONE_W      = 17;
  localparam int MIX_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  localparam int LEVEL_W     = 24;
  localparam int PROD0_W     = SAMPLE_BITS + GAIN_W;
  localparam int CW          = SAMPLE_BITS + 16;
  localparam int ZW          = LEVEL_W + 2;
  localparam int ANGLE_STEPS = 24;
  localparam int ANGLE_IDX_W = 5;

  localparam int MUL_A_W     = LEVEL_W + 1;
  localparam int MUL_B_W     = MIX_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam int FILT_SHIFT  = 18;
  localparam int MIX_SHIFT   = 24 - SAMPLE_BITS;
  localparam int OUT_SHIFT   = 40 - SAMPLE_BITS;
  localparam int ROUND_BIT   = 39 - SAMPLE_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX     = 2'd2;

  localparam logic [GAIN_W-1:0] DRIVE_GAIN_RESET  = 13'd1280;
  localparam logic [TONE_W-1:0] TONE_FACTOR_RESET = 17'd32768;
  localparam logic [MIX_W-1:0]  WET_MIX_RESET     = 17'd65536;
  localparam logic [MIX_W:0]    MIX_FULL          = 18'd65536;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          end_of_block_out;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_CSTART,
    S_CWAIT,
    S_FMUL,
    S_FUPD,
    S_MDRY,
    S_MWET,
    S_SUM,
    S_DONE
  } state_t;

  function automatic logic [LEVEL_W-1:0] angle_step(input logic [ANGLE_IDX_W-1:0] i);
    case (i)
      5'd0:    angle_step = 24'h400000;
      5'd1:    angle_step = 24'h25C80A;
      5'd2:    angle_step = 24'h13F671;
      5'd3:    angle_step = 24'h0A2224;
      5'd4:    angle_step = 24'h05161B;
      5'd5:    angle_step = 24'h028BB0;
      5'd6:    angle_step = 24'h0145EC;
      5'd7:    angle_step = 24'h00A2F9;
      5'd8:    angle_step = 24'h00517D;
      5'd9:    angle_step = 24'h0028BE;
      5'd10:   angle_step = 24'h00145F;
      5'd11:   angle_step = 24'h000A30;
      5'd12:   angle_step = 24'h000518;
      5'd13:   angle_step = 24'h00028C;
      5'd14:   angle_step = 24'h000146;
      5'd15:   angle_step = 24'h0000A3;
      5'd16:   angle_step = 24'h000051;
      5'd17:   angle_step = 24'h000029;
      5'd18:   angle_step = 24'h000014;
      5'd19:   angle_step = 24'h00000A;
      5'd20:   angle_step = 24'h000005;
      5'd21:   angle_step = 24'h000003;
      5'd22:   angle_step = 24'h000001;
      5'd23:   angle_step = 24'h000001;
      default: angle_step = 24'h000000;
    endcase
  endfunction

endpackage

FILE: hdl/aotm_cordic.sv
// Iterative vectoring CORDIC: one shift-add step per cycle, angle in Q1.23.
module aotm_cordic #(
  parameter int ITERS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [aotm_pkg::PROD0_W-1:0]  p,
  output aotm_pkg::cordic_stat_t               stat,
  output logic signed [aotm_pkg::LEVEL_W-1:0]  angle
);

  localparam int CW    = aotm_pkg::CW;
  localparam int ZW    = aotm_pkg::ZW;
  localparam int LW    = aotm_pkg::LEVEL_W;
  localparam int NIT   = (ITERS < aotm_pkg::ANGLE_STEPS) ? ITERS : aotm_pkg::ANGLE_STEPS;
  localparam int CNT_W = (NIT > 1) ? $clog2(NIT) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NIT - 1);
  localparam logic signed [ZW-1:0] ZMAX = ZW'((64'sd1 <<< (LW - 1)) - 1);
  localparam logic signed [ZW-1:0] ZMIN = -ZW'(64'sd1 <<< (LW - 1));

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] step;

  assign xs   = x >>> cnt;
  assign ys   = y >>> cnt;
  assign step = ZW'(signed'({1'b0, aotm_pkg::angle_step(aotm_pkg::ANGLE_IDX_W'(cnt))}));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CW'(64'sd1 <<< (aotm_pkg::SAMPLE_BITS + 7));
      y <= CW'(p);
      z <= '0;
    end else if (busy) begin
      if (!y[CW-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + step;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - step;
      end
    end
  end

  always_comb begin
    if (z > ZMAX) begin
      angle = LW'(ZMAX);
    end else if (z < ZMIN) begin
      angle = LW'(ZMIN);
    end else begin
      angle = LW'(z);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hdl/atan_overdrive_tone_mix.sv
// Top level: arctangent soft-clip overdrive with one-pole tone filter and dry/wet blend.
//
// Each sample transaction is taken when the block is idle and runs through a small
// sequencer: a drive multiply, CORDIC_ITERATIONS steps (at most 24) of the shift-add
// CORDIC unit, then filter and mix multiplies; all multiplies share one 25x18 multiplier.
// The block takes no new sample until the previous one has finished. The result
// sits in an output register, so the next sample is accepted while the previous
// result waits. The filter level carries across end-of-block markers.
// Configuration writes take effect on the next sample; they are to be made while
// the block is idle, and the block itself does not enforce this.
module atan_overdrive_tone_mix #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  aotm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output aotm_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [aotm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aotm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SB  = aotm_pkg::SAMPLE_BITS;
  localparam int LW  = aotm_pkg::LEVEL_W;
  localparam int AW  = aotm_pkg::MUL_A_W;
  localparam int BW  = aotm_pkg::MUL_B_W;
  localparam int PW  = aotm_pkg::PROD_W;
  localparam int SW  = LW + 2;
  localparam int RW  = PW - aotm_pkg::OUT_SHIFT;
  localparam logic signed [SW-1:0] LMAX = SW'((64'sd1 <<< (LW - 1)) - 1);
  localparam logic signed [SW-1:0] LMIN = -SW'(64'sd1 <<< (LW - 1));
  localparam logic signed [RW-1:0] OMAX = RW'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [RW-1:0] OMIN = -RW'(64'sd1 <<< (SB - 1));
  localparam logic signed [PW-1:0] ROUND = PW'(64'sd1 <<< aotm_pkg::ROUND_BIT);

  logic [aotm_pkg::GAIN_W-1:0] drive_gain;
  logic [aotm_pkg::TONE_W-1:0] tone_factor;
  logic [aotm_pkg::MIX_W-1:0]  wet_mix;

  aotm_pkg::state_t state;
  aotm_pkg::state_t state_next;

  logic signed [SB-1:0] dry;
  logic                 eob;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc;
  logic signed [LW-1:0] clip;
  logic signed [LW-1:0] level;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic                 cordic_start;
  logic                 out_load;

  aotm_pkg::cordic_stat_t        cordic_stat;
  logic signed [LW-1:0]          cordic_angle;
  logic signed [SW-1:0]          level_sum;
  logic signed [RW-1:0]          res_wide;
  logic signed [SB-1:0]          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain  <= aotm_pkg::DRIVE_GAIN_RESET;
      tone_factor <= aotm_pkg::TONE_FACTOR_RESET;
      wet_mix     <= aotm_pkg::WET_MIX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aotm_pkg::REG_DRIVE_GAIN:  drive_gain  <= cfg_data[aotm_pkg::GAIN_W-1:0];
        aotm_pkg::REG_TONE_FACTOR: tone_factor <= cfg_data[aotm_pkg::TONE_W-1:0];
        aotm_pkg::REG_WET_MIX:     wet_mix     <= cfg_data[aotm_pkg::MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aotm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state)
      aotm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = aotm_pkg::S_GAIN;
        end
      end
      aotm_pkg::S_GAIN: begin
        mul_a      = AW'(dry);
        mul_b      = BW'(signed'({1'b0, drive_gain}));
        state_next = aotm_pkg::S_CSTART;
      end
      aotm_pkg::S_CSTART: begin
        cordic_start = 1'b1;
        state_next   = aotm_pkg::S_CWAIT;
      end
      aotm_pkg::S_CWAIT: begin
        if (cordic_stat.done) begin
          state_next = aotm_pkg::S_FMUL;
        end
      end
      aotm_pkg::S_FMUL: begin
        mul_a      = AW'(clip) - AW'(level);
        mul_b      = BW'(signed'({1'b0, tone_factor}));
        state_next = aotm_pkg::S_FUPD;
      end
      aotm_pkg::S_FUPD: begin
        state_next = aotm_pkg::S_MDRY;
      end
      aotm_pkg::S_MDRY: begin
        mul_a      = AW'(dry) <<< aotm_pkg::MIX_SHIFT;
        mul_b      = signed'(aotm_pkg::MIX_FULL) - signed'({1'b0, wet_mix});
        state_next = aotm_pkg::S_MWET;
      end
      aotm_pkg::S_MWET: begin
        mul_a      = AW'(level);
        mul_b      = BW'(signed'({1'b0, wet_mix}));
        state_next = aotm_pkg::S_SUM;
      end
      aotm_pkg::S_SUM: begin
        state_next = aotm_pkg::S_DONE;
      end
      aotm_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = aotm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = aotm_pkg::S_IDLE;
      end
    endcase
  end

  aotm_cordic #(
    .ITERS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .p     (prod[aotm_pkg::PROD0_W-1:0]),
    .stat  (cordic_stat),
    .angle (cordic_angle)
  );

  assign level_sum = SW'(level) + SW'(signed'(prod[PW-1:aotm_pkg::FILT_SHIFT]));

  always_comb begin
    res_wide = acc[PW-1:aotm_pkg::OUT_SHIFT];
    if (res_wide > OMAX) begin
      res = SB'(OMAX);
    end else if (res_wide < OMIN) begin
      res = SB'(OMIN);
    end else begin
      res = SB'(res_wide);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_valid && in_ready) begin
      dry <= in_data.sample_in;
      eob <= in_data.end_of_block;
    end
    if (state == aotm_pkg::S_CWAIT && cordic_stat.done) begin
      clip <= cordic_angle;
    end
    if (state == aotm_pkg::S_MWET) begin
      acc <= prod;
    end
    if (state == aotm_pkg::S_SUM) begin
      acc <= acc + prod + ROUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (state == aotm_pkg::S_FUPD) begin
      if (level_sum > LMAX) begin
        level <= LW'(LMAX);
      end else if (level_sum < LMIN) begin
        level <= LW'(LMIN);
      end else begin
        level <= LW'(level_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.sample_out       <= res;
      out_data.end_of_block_out <= eob;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a sample is in flight");

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cordic_stat.done |-> (state == aotm_pkg::S_CWAIT))
    else $error("CORDIC finished outside its wait state");

  a_cordic_idle: assert property (@(posedge clk) disable iff (rst)
    (state == aotm_pkg::S_IDLE) |-> !cordic_stat.busy)
    else $error("CORDIC busy while the sequencer is idle");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == aotm_pkg::S_DONE))
    else $error("result presented without finishing a sample");

endmodule

FILE: bench/atan_overdrive_tone_mix_test.sv
`timescale 1ns / 100ps
// Testbench for atan_overdrive_tone_mix: directed table and random samples checked against a predictor.
module atan_overdrive_tone_mix_test;
  import aotm_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_STEPS = 24;
  localparam int SETTLE_CYCLES = CORDIC_STEPS + 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 100;
  localparam int PRINT_CAP = 50;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam longint LEVEL_HI = 64'sd8388607;
  localparam longint LEVEL_LO = -64'sd8388608;
  localparam longint OUT_HI = 64'sd32767;
  localparam longint OUT_LO = -64'sd32768;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic eob;
    bit typed;
    logic signed [SAMPLE_BITS-1:0] want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [GAIN_W-1:0] drive_cfg;
  logic [TONE_W-1:0] tone_cfg;
  logic [MIX_W-1:0] mix_cfg;
  longint filter_level;
  out_item_t mix_results_due [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  longint atan_steps [TABLE_STEPS] = '{
    64'h400000, 64'h25C80A, 64'h13F671, 64'hA2224, 64'h5161B, 64'h28BB0,
    64'h145EC, 64'hA2F9, 64'h517D, 64'h28BE, 64'h145F, 64'hA30,
    64'h518, 64'h28C, 64'h146, 64'hA3, 64'h51, 64'h29,
    64'h14, 64'hA, 64'h5, 64'h3, 64'h1, 64'h1
  };

  row_t plan [] = '{
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd32767, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd32768, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd1, 1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd1, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd16384, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_WET_MIX, 17'd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd32767, 1'b0, 1'b1, 16'sd32767},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd32768, 1'b1, 1'b1, -16'sd32768},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd0, 1'b0, 1'b1, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd1, 1'b0, 1'b1, -16'sd1},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd21845, 1'b1, 1'b1, 16'sd21845},
    '{ROW_CFG, REG_DRIVE_GAIN, 17'd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_WET_MIX, 17'd65536, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd32767, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd32768, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_DRIVE_GAIN, 17'd8191, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_TONE_FACTOR, 17'd131071, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd32767, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd32768, 1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd100, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_TONE_FACTOR, 17'd0, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd20000, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_WET_MIX, 17'd131071, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd32767, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd32768, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_NONE, 17'd1, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd5000, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_DRIVE_GAIN, 17'd256, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_TONE_FACTOR, 17'd3277, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_CFG, REG_WET_MIX, 17'd1, 16'sd0, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd32767, 1'b1, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, -16'sd32768, 1'b0, 1'b0, 16'sd0},
    '{ROW_ITEM, REG_NONE, 17'd0, 16'sd12, 1'b0, 1'b0, 16'sd0}
  };

  atan_overdrive_tone_mix #(
    .CORDIC_ITERATIONS(CORDIC_STEPS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint atan_clip(longint product);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = longint'(1) << (SAMPLE_BITS + 7);
    y = product;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS && i < TABLE_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_steps[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_steps[i];
      end
    end
    return clamp_range(z, LEVEL_LO, LEVEL_HI);
  endfunction

  // clip the drive product, advance the filter level and blend wet with dry
  function automatic out_item_t predict_overdrive(in_item_t item);
    longint dry;
    longint gain;
    longint tone;
    longint wet;
    longint clipped;
    longint acc;
    longint res;
    out_item_t r;
    dry = $signed(item.sample_in);
    gain = drive_cfg;
    tone = tone_cfg;
    wet = mix_cfg;
    clipped = atan_clip(dry * gain);
    filter_level = clamp_range(filter_level + ((tone * (clipped - filter_level)) >>> FILT_SHIFT),
                               LEVEL_LO, LEVEL_HI);
    acc = dry * (longint'(1) << MIX_SHIFT) * (longint'(65536) - wet) + filter_level * wet;
    acc = acc + (longint'(1) << ROUND_BIT);
    res = clamp_range(acc >>> OUT_SHIFT, OUT_LO, OUT_HI);
    r.sample_out = res[SAMPLE_BITS-1:0];
    r.end_of_block_out = item.end_of_block;
    return r;
  endfunction

  function automatic int pick_pause();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP)
      $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic push_sample(logic signed [SAMPLE_BITS-1:0] sample, logic eob, bit typed,
                             logic signed [SAMPLE_BITS-1:0] want);
    int gap;
    in_item_t item;
    out_item_t due;
    item.sample_in = sample;
    item.end_of_block = eob;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    due = predict_overdrive(item);
    if (typed)
      due.sample_out = want;
    mix_results_due.push_back(due);
  endtask

  // drop valid and drain every outstanding result before touching registers
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (mix_results_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DRIVE_GAIN: drive_cfg = val[GAIN_W-1:0];
      REG_TONE_FACTOR: tone_cfg = val[TONE_W-1:0];
      REG_WET_MIX: mix_cfg = val[MIX_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_reg(logic [CFG_IDX_W-1:0] idx);
    int r;
    r = $urandom_range(0, 3);
    case (idx)
      REG_DRIVE_GAIN: begin
        if (r == 0) return CFG_DATA_W'($urandom_range(0, 3) == 0 ? 0 : 8191);
        return CFG_DATA_W'($urandom_range(256, 5120));
      end
      REG_TONE_FACTOR: begin
        if (r == 0) return CFG_DATA_W'($urandom_range(0, 1) ? 3277 : 131071);
        return CFG_DATA_W'($urandom_range(3277, 65536));
      end
      default: begin
        if (r == 0) return CFG_DATA_W'($urandom_range(0, 1) ? 0 : 131071);
        return CFG_DATA_W'($urandom_range(0, 65536));
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SAMPLE_BITS'($urandom_range(0, 65535));
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return 16'sd0;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    return SAMPLE_BITS'($urandom_range(0, 511) - 256);
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t due;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (mix_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction sample_out=%0d",
                                    $signed(out_data.sample_out)));
        end else begin
          due = mix_results_due.pop_front();
          if (out_data.sample_out !== due.sample_out)
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      $signed(out_data.sample_out), $signed(due.sample_out)));
          if (out_data.end_of_block_out !== due.end_of_block_out)
            report_mismatch($sformatf("end_of_block_out %b, expected %b",
                                      out_data.end_of_block_out, due.end_of_block_out));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = pick_pause();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    drive_cfg = DRIVE_GAIN_RESET;
    tone_cfg = TONE_FACTOR_RESET;
    mix_cfg = WET_MIX_RESET;
    filter_level = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].kind == ROW_CFG) begin
        settle_idle();
        write_reg(plan[n].reg_idx, plan[n].reg_val);
      end else begin
        push_sample(plan[n].sample, plan[n].eob, plan[n].typed, plan[n].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle_idle();
      calm = (phase % 4 == 3);
      write_reg(REG_DRIVE_GAIN, pick_reg(REG_DRIVE_GAIN));
      write_reg(REG_TONE_FACTOR, pick_reg(REG_TONE_FACTOR));
      write_reg(REG_WET_MIX, pick_reg(REG_WET_MIX));
      for (int k = 0; k < PHASE_ITEMS; k++)
        push_sample(pick_sample(), ($urandom_range(0, 7) == 0), 1'b0, '0);
    end

    settle_idle();
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/aotm_pkg.sv
hdl/aotm_cordic.sv
hdl/atan_overdrive_tone_mix.sv
bench/atan_overdrive_tone_mix_test.sv
